[rtl/core/pdmc_pkg.sv]
package pdmc_pkg;

  localparam int unsigned FULL_SCALE_RAW = 930;
  localparam int unsigned POT_COUNT = 6;
  localparam int unsigned RAW_W = 12;
  localparam int unsigned POT_W = $clog2(POT_COUNT);
  localparam logic [POT_W-1:0] SKIPPED_POT = POT_W'(3);
  localparam logic [POT_W-1:0] LAST_POT = POT_W'(POT_COUNT - 1);

  // Config register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_PERIOD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_HOLD = 2'd3;

  localparam logic [11:0] DEADBAND_RST = 12'd10;
  localparam logic [15:0] SLOW_PERIOD_RST = 16'd500;
  localparam logic [15:0] FAST_PERIOD_RST = 16'd80;
  localparam logic [15:0] FAST_HOLD_RST = 16'd1000;

  // Packet bytes.
  localparam logic [7:0] BYTE_HEADER = 8'h80;
  localparam logic [7:0] BYTE_CC_STATUS = 8'hB0;
  localparam logic [7:0] CC_MAX = 8'h7F;

  // Scaling by 127 / FULL_SCALE_RAW: multiply by a rounded-up reciprocal,
  // exact for every 12-bit reading.
  localparam int unsigned SCALE_SHIFT = 32;
  localparam int unsigned SCALED_W = RAW_W + 7;
  localparam int unsigned MULT_W = SCALE_SHIFT + 1;
  localparam logic [63:0] SCALE_MULT_WIDE =
      ((64'd1 << SCALE_SHIFT) + 64'(FULL_SCALE_RAW) - 64'd1) / 64'(FULL_SCALE_RAW);
  localparam logic [MULT_W-1:0] SCALE_MULT = SCALE_MULT_WIDE[MULT_W-1:0];
  localparam int unsigned PROD_W = SCALED_W + MULT_W;
  localparam int unsigned QUOT_W = PROD_W - SCALE_SHIFT;

  typedef struct packed {
    logic        command;
    logic [11:0] pot0_raw;
    logic [11:0] pot1_raw;
    logic [11:0] pot2_raw;
    logic [11:0] pot3_raw;
    logic [11:0] pot4_raw;
    logic [11:0] pot5_raw;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  packet_byte;
    logic        end_of_packet;
    logic        is_schedule;
    logic [15:0] next_period_ms;
    logic        last;
  } out_item_t;

  // Microcode.
  localparam int unsigned STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_SCAN_POT = 4'd1;
  localparam step_t STEP_SCAN_NEXT = 4'd7;
  localparam step_t STEP_SNAP_HEAD = 4'd9;
  localparam step_t STEP_SNAP_POT = 4'd10;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_HEADER,
    EMIT_STATUS,
    EMIT_CC_NUM,
    EMIT_VALUE,
    EMIT_SCHED
  } emit_e;

  typedef enum logic [1:0] {
    EOP_NO,
    EOP_YES,
    EOP_LAST_POT
  } eop_e;

  typedef enum logic [1:0] {
    POT_HOLD,
    POT_CLEAR,
    POT_NEXT_SKIP,
    POT_NEXT_ALL
  } pot_op_e;

  typedef enum logic [1:0] {
    COND_NEVER,
    COND_SNAPSHOT,
    COND_QUIET,
    COND_MORE_POTS
  } cond_e;

  typedef struct packed {
    emit_e   emit;
    eop_e    eop;
    pot_op_e pot_op;
    logic    load;
    logic    store;
    logic    mark;
    cond_e   cond;
    step_t   target;
    logic    done;
  } uword_t;

  typedef struct packed {
    logic   fire;
    logic   capture;
    uword_t uw;
  } ctrl_t;

  typedef struct packed {
    logic snapshot;
    logic quiet;
    logic more_pots;
    logic out_free;
  } status_t;

  function automatic logic [7:0] cc_number(input logic [POT_W-1:0] pot);
    logic [7:0] cc;
    unique case (pot)
      3'd0: cc = 8'd4;
      3'd1: cc = 8'd2;
      3'd2: cc = 8'd0;
      3'd3: cc = 8'd5;
      3'd4: cc = 8'd3;
      3'd5: cc = 8'd1;
      default: cc = 8'd0;
    endcase
    return cc;
  endfunction

endpackage

[rtl/core/pdmc_ucode_rom.sv]
module pdmc_ucode_rom (
  input  pdmc_pkg::step_t  step_i,
  output pdmc_pkg::uword_t uword_o
);
  import pdmc_pkg::*;

  localparam uword_t UW_NOP = '{
    emit: EMIT_NONE, eop: EOP_NO, pot_op: POT_HOLD, load: 1'b0, store: 1'b0,
    mark: 1'b0, cond: COND_NEVER, target: '0, done: 1'b0
  };

  always_comb begin
    uword_o = UW_NOP;
    unique case (step_i)
      // Dispatch on the command.
      4'd0: begin
        uword_o.pot_op = POT_CLEAR;
        uword_o.cond   = COND_SNAPSHOT;
        uword_o.target = STEP_SNAP_HEAD;
      end
      // Scan loop: scale the reading and skip the pot if it stayed in the deadband.
      4'd1: begin
        uword_o.load   = 1'b1;
        uword_o.cond   = COND_QUIET;
        uword_o.target = STEP_SCAN_NEXT;
      end
      4'd2: uword_o.emit = EMIT_HEADER;
      4'd3: uword_o.emit = EMIT_HEADER;
      4'd4: uword_o.emit = EMIT_STATUS;
      4'd5: uword_o.emit = EMIT_CC_NUM;
      4'd6: begin
        uword_o.emit  = EMIT_VALUE;
        uword_o.eop   = EOP_YES;
        uword_o.store = 1'b1;
        uword_o.mark  = 1'b1;
      end
      4'd7: begin
        uword_o.pot_op = POT_NEXT_SKIP;
        uword_o.cond   = COND_MORE_POTS;
        uword_o.target = STEP_SCAN_POT;
      end
      4'd8: begin
        uword_o.emit = EMIT_SCHED;
        uword_o.done = 1'b1;
      end
      // Snapshot: one header, then four bytes for every pot.
      4'd9: begin
        uword_o.emit = EMIT_HEADER;
        uword_o.mark = 1'b1;
      end
      4'd10: begin
        uword_o.emit = EMIT_HEADER;
        uword_o.load = 1'b1;
      end
      4'd11: uword_o.emit = EMIT_STATUS;
      4'd12: uword_o.emit = EMIT_CC_NUM;
      4'd13: begin
        uword_o.emit   = EMIT_VALUE;
        uword_o.eop    = EOP_LAST_POT;
        uword_o.store  = 1'b1;
        uword_o.pot_op = POT_NEXT_ALL;
        uword_o.cond   = COND_MORE_POTS;
        uword_o.target = STEP_SNAP_POT;
      end
      4'd14: begin
        uword_o.emit = EMIT_SCHED;
        uword_o.done = 1'b1;
      end
      default: begin
        uword_o.done = 1'b1;
      end
    endcase
  end

endmodule

[rtl/core/pdmc_sequencer.sv]
module pdmc_sequencer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pdmc_pkg::status_t  status_i,
  output pdmc_pkg::ctrl_t    ctrl_o
);
  import pdmc_pkg::*;

  logic   busy_q, busy_d;
  step_t  step_q, step_d;
  uword_t uw;
  logic   taken;

  pdmc_ucode_rom u_rom (
    .step_i  (step_q),
    .uword_o (uw)
  );

  always_comb begin
    unique case (uw.cond)
      COND_NEVER:     taken = 1'b0;
      COND_SNAPSHOT:  taken = status_i.snapshot;
      COND_QUIET:     taken = status_i.quiet;
      COND_MORE_POTS: taken = status_i.more_pots;
      default:        taken = 1'b0;
    endcase
  end

  assign in_ready_o = !busy_q;

  always_comb begin
    ctrl_o.uw      = uw;
    ctrl_o.capture = in_valid_i && !busy_q;
    // A step that emits waits until the output register can take the transaction.
    ctrl_o.fire    = busy_q && ((uw.emit == EMIT_NONE) || status_i.out_free);

    busy_d = busy_q;
    step_d = step_q;
    if (ctrl_o.capture) begin
      busy_d = 1'b1;
      step_d = '0;
    end else if (ctrl_o.fire) begin
      if (uw.done) begin
        busy_d = 1'b0;
      end else if (taken) begin
        step_d = uw.target;
      end else begin
        step_d = step_q + step_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

endmodule

[rtl/core/pdmc_datapath.sv]
module pdmc_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [pdmc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [pdmc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  pdmc_pkg::in_item_t                   in_data_i,
  input  pdmc_pkg::ctrl_t                      ctrl_i,
  output pdmc_pkg::status_t                    status_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output pdmc_pkg::out_item_t                  out_data_o
);
  import pdmc_pkg::*;

  logic [11:0] deadband_q;
  logic [15:0] slow_period_q, fast_period_q, fast_hold_q;

  in_item_t             in_q;
  logic [POT_W-1:0]     pot_q, pot_d;
  logic [RAW_W-1:0]     stored_q [POT_COUNT];
  logic [31:0]          last_change_q;
  logic                 changed_q;
  logic [PROD_W-1:0]    prod_q;
  logic                 out_valid_q;
  out_item_t            out_q, out_d;

  logic [RAW_W-1:0]     raw_sel;
  logic [RAW_W-1:0]     old_sel;
  logic [RAW_W-1:0]     diff;
  logic [SCALED_W-1:0]  scaled;
  logic [QUOT_W-1:0]    quot;
  logic [7:0]           cc_value;
  logic [31:0]          elapsed;
  logic [15:0]          period;
  logic                 emit_now;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q    <= DEADBAND_RST;
      slow_period_q <= SLOW_PERIOD_RST;
      fast_period_q <= FAST_PERIOD_RST;
      fast_hold_q   <= FAST_HOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DEADBAND:    deadband_q    <= cfg_data_i[11:0];
        CFG_SLOW_PERIOD: slow_period_q <= cfg_data_i;
        CFG_FAST_PERIOD: fast_period_q <= cfg_data_i;
        CFG_FAST_HOLD:   fast_hold_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (pot_q)
      3'd0: raw_sel = in_q.pot0_raw;
      3'd1: raw_sel = in_q.pot1_raw;
      3'd2: raw_sel = in_q.pot2_raw;
      3'd3: raw_sel = in_q.pot3_raw;
      3'd4: raw_sel = in_q.pot4_raw;
      3'd5: raw_sel = in_q.pot5_raw;
      default: raw_sel = '0;
    endcase
  end

  assign old_sel = stored_q[pot_q];
  assign diff    = (raw_sel > old_sel) ? (raw_sel - old_sel) : (old_sel - raw_sel);

  // 127 * raw as a shift and subtract.
  assign scaled = ({raw_sel, 7'd0}) - SCALED_W'(raw_sel);
  assign quot   = prod_q[PROD_W-1:SCALE_SHIFT];
  assign cc_value = (quot > QUOT_W'(CC_MAX)) ? CC_MAX : quot[7:0];

  // Once a pot has been sent in this scan the fast period is chosen, whatever the elapsed time.
  assign elapsed = in_q.now_ms - last_change_q;
  always_comb begin
    if (in_q.command) begin
      period = '0;
    end else if (!changed_q && (elapsed > {16'd0, fast_hold_q})) begin
      period = slow_period_q;
    end else begin
      period = fast_period_q;
    end
  end

  always_comb begin
    unique case (ctrl_i.uw.pot_op)
      POT_HOLD:      pot_d = pot_q;
      POT_CLEAR:     pot_d = '0;
      POT_NEXT_SKIP: pot_d = (pot_q + POT_W'(1) == SKIPPED_POT) ? pot_q + POT_W'(2)
                                                                : pot_q + POT_W'(1);
      POT_NEXT_ALL:  pot_d = pot_q + POT_W'(1);
      default:       pot_d = pot_q;
    endcase
  end

  always_comb begin
    out_d = '0;
    unique case (ctrl_i.uw.emit)
      EMIT_HEADER: out_d.packet_byte = BYTE_HEADER;
      EMIT_STATUS: out_d.packet_byte = BYTE_CC_STATUS;
      EMIT_CC_NUM: out_d.packet_byte = cc_number(pot_q);
      EMIT_VALUE:  out_d.packet_byte = cc_value;
      EMIT_SCHED: begin
        out_d.is_schedule    = 1'b1;
        out_d.next_period_ms = period;
        out_d.last           = 1'b1;
      end
      default: ;
    endcase
    unique case (ctrl_i.uw.eop)
      EOP_NO:       out_d.end_of_packet = 1'b0;
      EOP_YES:      out_d.end_of_packet = 1'b1;
      EOP_LAST_POT: out_d.end_of_packet = (pot_q == LAST_POT);
      default:      out_d.end_of_packet = 1'b0;
    endcase
  end

  assign emit_now = ctrl_i.fire && (ctrl_i.uw.emit != EMIT_NONE);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      in_q <= in_data_i;
    end
    if (ctrl_i.fire && ctrl_i.uw.load) begin
      prod_q <= PROD_W'(scaled) * PROD_W'(SCALE_MULT);
    end
    if (emit_now) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pot_q         <= '0;
      changed_q     <= 1'b0;
      last_change_q <= '0;
      out_valid_q   <= 1'b0;
      for (int i = 0; i < POT_COUNT; i++) begin
        stored_q[i] <= '0;
      end
    end else begin
      if (ctrl_i.capture) begin
        changed_q <= 1'b0;
      end else if (ctrl_i.fire && ctrl_i.uw.mark) begin
        changed_q <= 1'b1;
      end
      if (ctrl_i.fire) begin
        pot_q <= pot_d;
        if (ctrl_i.uw.store) begin
          stored_q[pot_q] <= raw_sel;
        end
        if ((ctrl_i.uw.emit == EMIT_SCHED) && changed_q) begin
          last_change_q <= in_q.now_ms;
        end
      end
      if (emit_now) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.snapshot  = in_q.command;
  assign status_o.quiet     = (diff <= deadband_q);
  assign status_o.more_pots = (pot_q != LAST_POT);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[rtl/core/pot_deadband_midi_cc_packetizer_core.sv]
// An emitting microcode step stalls while the output is held. A scan runs 12 steps
// plus 5 for each pot sent; a snapshot runs 27 steps. No input is accepted while busy.
// A snapshot's first result is registered by its header step, after the dispatch step;
// a scan's comes after the dispatch step and at least one load step. The next input is
// accepted the cycle after the schedule is registered.
// Reset restores the default configuration and clears stored readings and change time.
module pot_deadband_midi_cc_packetizer_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pdmc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [pdmc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  pdmc_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output pdmc_pkg::out_item_t               out_data_o
);
  import pdmc_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  pdmc_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  pdmc_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
